### rtl/wtw_pkg.sv
// ----------------------------------------------------------------------------
// Windowed triangle wave package
// Register indexes and reset constants shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package wtw_pkg;

  localparam int unsigned CfgIndexWidth = 3;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_WINDOW_START  = 3'd0,
    REG_WINDOW_FINISH = 3'd1,
    REG_WAVE_PERIOD   = 3'd2,
    REG_PHASE_SHIFT   = 3'd3,
    REG_AMPLITUDE     = 3'd4
  } cfg_index_e;

  // 1.0 in the Q.16 format of period and amplitude.
  localparam int unsigned FixedOne = 65536;

endpackage

`default_nettype wire

### rtl/wtw_div_cell.sv
// ----------------------------------------------------------------------------
// Division cell
// One restoring division step with its own valid/ready beat register.
// ----------------------------------------------------------------------------
`default_nettype none

module wtw_div_cell #(
  parameter int unsigned RW = 47,
  parameter int unsigned XW = 49,
  parameter int unsigned SW = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [RW-1:0] divisor_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire logic [RW-1:0] rem_i,
  input  wire logic [XW-1:0] quo_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output logic [RW-1:0]      rem_o,
  output logic [XW-1:0]      quo_o,
  output logic [SW-1:0]      side_o
);

  logic          valid_q;
  logic [RW:0]   trial;
  logic          fits;
  logic [RW:0]   diff;
  logic [RW-1:0] rem_d, rem_q;
  logic [XW-1:0] quo_d, quo_q;
  logic [SW-1:0] side_q;

  assign trial = {rem_i, quo_i[XW-1]};
  assign fits  = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};
  assign rem_d = fits ? diff[RW-1:0] : trial[RW-1:0];
  assign quo_d = {quo_i[XW-2:0], fits};

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

### rtl/wtw_div_row.sv
// ----------------------------------------------------------------------------
// Division row
// A chain of division cells, one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module wtw_div_row #(
  parameter int unsigned RW = 47,
  parameter int unsigned XW = 49,
  parameter int unsigned SW = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [RW-1:0] divisor_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire logic [RW-1:0] rem_i,
  input  wire logic [XW-1:0] quo_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output logic [RW-1:0]      rem_o,
  output logic [XW-1:0]      quo_o,
  output logic [SW-1:0]      side_o
);

  logic          vld [XW+1];
  logic          rdy [XW+1];
  logic [RW-1:0] rem [XW+1];
  logic [XW-1:0] quo [XW+1];
  logic [SW-1:0] side [XW+1];

  assign vld[0]  = valid_i;
  assign rem[0]  = rem_i;
  assign quo[0]  = quo_i;
  assign side[0] = side_i;
  assign ready_o = rdy[0];

  for (genvar k = 0; k < XW; k++) begin : g_cell
    wtw_div_cell #(.RW(RW), .XW(XW), .SW(SW)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .divisor_i(divisor_i),
      .valid_i  (vld[k]),
      .ready_o  (rdy[k]),
      .rem_i    (rem[k]),
      .quo_i    (quo[k]),
      .side_i   (side[k]),
      .valid_o  (vld[k+1]),
      .ready_i  (rdy[k+1]),
      .rem_o    (rem[k+1]),
      .quo_o    (quo[k+1]),
      .side_o   (side[k+1])
    );
  end

  assign rdy[XW]  = ready_i;
  assign valid_o  = vld[XW];
  assign rem_o    = rem[XW];
  assign quo_o    = quo[XW];
  assign side_o   = side[XW];

endmodule

`default_nettype wire

### rtl/windowed_triangle_wave.sv
// Throughput: one beat per cycle; each stage holds its beat only while stalled.
// The phase comes from a row of TIME_WIDTH + 1 division cells and the wave value
// from a row of VALUE_WIDTH + 2 division cells, one quotient bit per cell.
// Reset empties the pipeline and loads the register defaults (period and
// amplitude 1.0, window and shift zero).
// ----------------------------------------------------------------------------
// Windowed triangle wave
// Triangle wave of a sample time inside a closed window, zero outside it.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_triangle_wave #(
  parameter int unsigned TIME_WIDTH  = 48,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [wtw_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [((TIME_WIDTH > VALUE_WIDTH) ? TIME_WIDTH : VALUE_WIDTH)-1:0]
                                              cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [TIME_WIDTH-1:0]          sample_time_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [VALUE_WIDTH-1:0]              wave_value_o
);

  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned PW = TW - 1;
  localparam int unsigned LH = PW / 2;
  localparam int unsigned UH = PW - LH;
  localparam int unsigned MW = VW + PW;
  localparam int unsigned NW = VW + TW + 2;
  localparam int unsigned QW = VW + 2;
  localparam int unsigned SW = VW + 4;

  // Configuration registers.
  logic signed [TW-1:0] win_start_q, win_finish_q, shift_q;
  logic [PW-1:0]        period_q;
  logic signed [VW-1:0] amp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q  <= '0;
      win_finish_q <= '0;
      shift_q      <= '0;
      period_q     <= PW'(wtw_pkg::FixedOne);
      amp_q        <= VW'(wtw_pkg::FixedOne);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wtw_pkg::REG_WINDOW_START:  win_start_q  <= cfg_data_i[TW-1:0];
        wtw_pkg::REG_WINDOW_FINISH: win_finish_q <= cfg_data_i[TW-1:0];
        wtw_pkg::REG_WAVE_PERIOD: begin
          if (cfg_data_i[PW-1:0] == '0) begin
            period_q <= PW'(wtw_pkg::FixedOne);
          end else begin
            period_q <= cfg_data_i[PW-1:0];
          end
        end
        wtw_pkg::REG_PHASE_SHIFT:   shift_q <= cfg_data_i[TW-1:0];
        wtw_pkg::REG_AMPLITUDE:     amp_q   <= cfg_data_i[VW-1:0];
        default: ;
      endcase
    end
  end

  logic          amp_neg;
  logic [VW-1:0] amp_mag;
  assign amp_neg = amp_q[VW-1];
  assign amp_mag = amp_neg ? VW'(-amp_q) : amp_q;

  // Stage 0: window check and shifted time.
  logic              v0_q, rdy0, r1_rdy;
  logic              win0_q, neg0_q;
  logic [TW:0]       mag0_q;
  logic signed [TW:0] tsum;
  logic              in_win;

  assign tsum   = {sample_time_i[TW-1], sample_time_i} + {shift_q[TW-1], shift_q};
  assign in_win = ($signed(win_start_q) <= $signed(sample_time_i)) &&
                  ($signed(sample_time_i) <= $signed(win_finish_q));
  assign rdy0       = !v0_q || r1_rdy;
  assign in_ready_o = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy0) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      win0_q <= in_win;
      neg0_q <= tsum[TW];
      mag0_q <= tsum[TW] ? (TW+1)'(-tsum) : tsum;
    end
  end

  // Phase row: remainder of the magnitude by the period.
  logic          r1_v, rdy1;
  logic [PW-1:0] r1_rem;
  logic [TW:0]   r1_quo;
  logic [1:0]    r1_side;

  wtw_div_row #(.RW(PW), .XW(TW + 1), .SW(2)) u_phase_row (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .divisor_i(period_q),
    .valid_i  (v0_q),
    .ready_o  (r1_rdy),
    .rem_i    ('0),
    .quo_i    (mag0_q),
    .side_i   ({win0_q, neg0_q}),
    .valid_o  (r1_v),
    .ready_i  (rdy1),
    .rem_o    (r1_rem),
    .quo_o    (r1_quo),
    .side_o   (r1_side)
  );

  // Stage 1: floor modulo correction.
  logic          v1_q, rdy2, win1_q;
  logic [PW-1:0] p1_q;
  logic          unused_quo;
  assign unused_quo = ^r1_quo;
  assign rdy1 = !v1_q || rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= r1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      win1_q <= r1_side[1] & ~unused_quo | r1_side[1] & unused_quo;
      p1_q   <= (r1_side[0] && (r1_rem != '0)) ? period_q - r1_rem : r1_rem;
    end
  end

  // Stage 2: partial products of amplitude magnitude and phase.
  logic             v2_q, rdy3, win2_q;
  logic [PW-1:0]    p2_q;
  logic [VW+LH-1:0] lo2_q;
  logic [VW+UH-1:0] hi2_q;
  assign rdy2 = !v2_q || rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      win2_q <= win1_q;
      p2_q   <= p1_q;
      lo2_q  <= amp_mag * p1_q[LH-1:0];
      hi2_q  <= amp_mag * p1_q[PW-1:LH];
    end
  end

  // Stage 3: full product.
  logic          v3_q, rdy4, win3_q;
  logic [PW-1:0] p3_q;
  logic [MW-1:0] prod3_q;
  assign rdy3 = !v3_q || rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      win3_q  <= win2_q;
      p3_q    <= p2_q;
      prod3_q <= {hi2_q, LH'(0)} + MW'(lo2_q);
    end
  end

  // Stage 4: dividend with rounding bias.
  logic          v4_q, r2_rdy, win4_q;
  logic [PW-1:0] p4_q;
  logic [NW-1:0] num4_q;
  assign rdy4 = !v4_q || r2_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      win4_q <= win3_q;
      p4_q   <= p3_q;
      num4_q <= {prod3_q, 3'b000} + NW'(period_q) - NW'(amp_neg);
    end
  end

  // Scale row: rounded quotient by twice the period.
  logic          r2_v, rdy5;
  logic [TW-1:0] r2_rem;
  logic [QW-1:0] r2_quo;
  logic [TW-1:0] r2_side;

  wtw_div_row #(.RW(TW), .XW(QW), .SW(TW)) u_scale_row (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .divisor_i({period_q, 1'b0}),
    .valid_i  (v4_q),
    .ready_o  (r2_rdy),
    .rem_i    (num4_q[NW-1:QW]),
    .quo_i    (num4_q[QW-1:0]),
    .side_i   ({win4_q, p4_q}),
    .valid_o  (r2_v),
    .ready_i  (rdy5),
    .rem_o    (r2_rem),
    .quo_o    (r2_quo),
    .side_o   (r2_side)
  );

  // Stage 5: wave segment, saturation and window gate.
  logic                 v5_q;
  logic [VW-1:0]        wave5_q;
  logic [PW-1:0]        p5;
  logic [PW-1:0]        quarter, quarter_up;
  logic signed [SW-1:0] xs, as, w, wmax, wmin;
  logic [VW-1:0]        wsat;
  logic                 unused_rem;

  assign unused_rem = ^r2_rem;
  assign p5         = r2_side[PW-1:0];
  assign quarter    = period_q >> 2;
  assign quarter_up = quarter + PW'(period_q[1:0] != 2'b00);
  assign xs   = amp_neg ? -$signed(SW'(r2_quo)) : $signed(SW'(r2_quo));
  assign as   = SW'(amp_q);
  assign wmax = $signed({{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}});
  assign wmin = $signed({{(SW-VW+1){1'b1}}, {(VW-1){1'b0}}});

  always_comb begin
    priority if (p5 < quarter_up) begin
      w = xs;
    end else if ((period_q - p5) > quarter) begin
      w = (as <<< 1) - xs;
    end else begin
      w = xs - (as <<< 2);
    end
    priority if (w > wmax) begin
      wsat = wmax[VW-1:0];
    end else if (w < wmin) begin
      wsat = wmin[VW-1:0];
    end else begin
      wsat = w[VW-1:0];
    end
  end

  assign rdy5 = !v5_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (rdy5) begin
      v5_q <= r2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      wave5_q <= (r2_side[TW-1] & (unused_rem | ~unused_rem)) ? wsat : '0;
    end
  end

  assign out_valid_o  = v5_q;
  assign wave_value_o = wave5_q;

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Windowed triangle wave testbench
// Drives sample times through the block under several window, period, shift
// and amplitude settings, predicts each wave value and compares results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int unsigned TW = 48;
  localparam int unsigned VW = 32;
  localparam int unsigned LATENCY = TW + VW + 9;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  wtw_pkg::cfg_index_e cfg_index;
  logic [TW-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [TW-1:0] sample_time;
  logic out_valid;
  logic out_ready;
  logic [VW-1:0] wave_value;

  logic signed [TW-1:0] win_start, win_finish, shift;
  logic [TW-2:0] period;
  logic signed [VW-1:0] amp;

  logic [VW-1:0] wave_q[$];
  int errors;
  int send_idle;
  int recv_idle;

  windowed_triangle_wave u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .sample_time_i(sample_time),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .wave_value_o (wave_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [VW-1:0] wave_of(logic signed [TW-1:0] t);
    logic signed [127:0] tt, pp, ph, aa, num, x, w, vmax, vmin;
    if (t < win_start || t > win_finish) return '0;
    pp = period;
    tt = t;
    ph = (tt + shift) % pp;
    if (ph < 0) ph = ph + pp;
    aa = amp;
    num = 8 * aa * ph + pp;
    // Floor division of num by 2P.
    x = num / (2 * pp);
    if (num < 0 && x * 2 * pp != num) x = x - 1;
    if (4 * ph < pp) w = x;
    else if (4 * ph < 3 * pp) w = 2 * aa - x;
    else w = x - 4 * aa;
    vmax = (128'sd1 <<< (VW - 1)) - 1;
    vmin = -vmax - 1;
    if (w > vmax) w = vmax;
    if (w < vmin) w = vmin;
    return w[VW-1:0];
  endfunction

  task automatic report(input string what, input logic [VW-1:0] got,
                        input logic [VW-1:0] want);
    errors++;
    $display("ERROR %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (wave_q.size() == 0) report("unexpected beat", wave_value, '0);
        else begin
          if (wave_value !== wave_q[0]) report("wave_value", wave_value, wave_q[0]);
          void'(wave_q.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(input wtw_pkg::cfg_index_e idx, input logic [TW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      wtw_pkg::REG_WINDOW_START:  win_start = data;
      wtw_pkg::REG_WINDOW_FINISH: win_finish = data;
      wtw_pkg::REG_WAVE_PERIOD:
        period = (data[TW-2:0] == '0) ? (TW-1)'(wtw_pkg::FixedOne) : data[TW-2:0];
      wtw_pkg::REG_PHASE_SHIFT:   shift = data;
      wtw_pkg::REG_AMPLITUDE:     amp = data[VW-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (wave_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_all(input logic [TW-1:0] s, input logic [TW-1:0] f,
                         input logic [TW-1:0] p, input logic [TW-1:0] ph,
                         input logic [TW-1:0] a);
    drain();
    write_reg(wtw_pkg::REG_WINDOW_START, s);
    write_reg(wtw_pkg::REG_WINDOW_FINISH, f);
    write_reg(wtw_pkg::REG_WAVE_PERIOD, p);
    write_reg(wtw_pkg::REG_PHASE_SHIFT, ph);
    write_reg(wtw_pkg::REG_AMPLITUDE, a);
  endtask

  task automatic send_sample(input logic [TW-1:0] t);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_time <= t;
    do @(posedge clk); while (!in_ready);
    wave_q.push_back(wave_of(t));
  endtask

  function automatic logic [TW-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return r[TW-1:0];
      1: return {{(TW-24){r[23]}}, r[23:0]};
      2: return {{(TW-32){r[31]}}, r[31:0]};
      default: return TW'($urandom_range(8) * 64'(period) / 4 + $urandom_range(2) - 1);
    endcase
  endfunction

  task automatic test_directed();
    logic [TW-1:0] tmax, tmin;
    tmax = {1'b0, {(TW-1){1'b1}}};
    tmin = {1'b1, {(TW-1){1'b0}}};
    set_all(tmin, tmax, '0, '0, TW'(32'h0001_0000));
    for (int q = 0; q <= 4; q++) send_sample(TW'(q * 16384));
    send_sample(tmax);
    send_sample(tmin);
    send_sample('1);
    set_all(TW'(100), TW'(200), TW'(4 * 7 + 1), TW'(-5), TW'({1'b1, {(VW-1){1'b0}}}));
    send_sample(TW'(99));
    send_sample(TW'(100));
    send_sample(TW'(150));
    send_sample(TW'(200));
    send_sample(TW'(201));
    set_all(tmin, tmax, tmax, tmax, TW'({1'b0, {(VW-1){1'b1}}}));
    send_sample(tmax);
    send_sample(tmin);
    send_sample(tmax >> 2);
    set_all(tmin, tmax, TW'(3), tmin, TW'({(VW){1'b1}}));
    send_sample('0);
    send_sample(TW'(1));
    send_sample(TW'(2));
    set_all(TW'(10), TW'(5), TW'(65536), '0, TW'(65536));
    send_sample(TW'(7));
    // An index beyond the register list must be ignored.
    drain();
    write_reg(wtw_pkg::cfg_index_e'(3'd7), tmax);
    set_all(tmin, tmax, TW'(65536), '0, TW'(65536));
    send_sample(TW'(16384));
  endtask

  task automatic test_random(input int count);
    logic [63:0] r, rs, rf;
    logic [TW-1:0] s, f, p;
    for (int k = 0; k < count; k++) begin
      if (k % 60 == 0) begin
        r = {$urandom, $urandom};
        rs = {$urandom, $urandom};
        rf = {$urandom, $urandom};
        if ($urandom_range(3) == 0) s = rs[TW-1:0];
        else s = TW'(-64'($urandom_range(1 << 22)));
        if ($urandom_range(3) == 0) f = rf[TW-1:0];
        else f = TW'($urandom_range(1 << 22));
        if ($urandom_range(2) == 0) p = r[TW-1:0];
        else p = TW'($urandom_range(1 << 20));
        set_all(s, f, p, TW'({$urandom, $urandom}), TW'($urandom));
      end
      send_sample(rand_time());
    end
  endtask

  task automatic test_pause();
    for (int k = 0; k < 10; k++) send_sample(rand_time());
    drain();
    for (int k = 0; k < 10; k++) send_sample(rand_time());
  endtask

  initial begin
    errors = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = wtw_pkg::REG_WINDOW_START;
    cfg_data = '0;
    in_valid = 1'b0;
    sample_time = '0;
    out_ready = 1'b0;
    win_start = '0;
    win_finish = '0;
    period = (TW-1)'(wtw_pkg::FixedOne);
    shift = '0;
    amp = VW'(wtw_pkg::FixedOne);
    send_idle = 25;
    recv_idle = 46;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(260);
    send_idle = 46;
    recv_idle = 25;
    test_pause();
    test_random(260);
    send_idle = 0;
    recv_idle = 0;
    test_random(280);
    drain();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
